### rtl/racket_motor_sequencer_defines.svh
// assertion macros shared by the racket motor sequencer rtl
`ifndef RACKET_MOTOR_SEQUENCER_DEFINES_SVH
`define RACKET_MOTOR_SEQUENCER_DEFINES_SVH

// same-cycle implication, checked at every rising edge outside reset
`define RMS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define RMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/rms_pkg.sv
// package with codes, constants and helpers of the racket motor sequencer
`timescale 1ns / 1ps

package rms_pkg;

	// request kinds
	localparam logic [2:0] KIND_UPDATE      = 3'd0;
	localparam logic [2:0] KIND_LOW_MOVE    = 3'd1;
	localparam logic [2:0] KIND_LOW_CAL     = 3'd2;
	localparam logic [2:0] KIND_HIGH_MOVE   = 3'd3;
	localparam logic [2:0] KIND_HIGH_CAL    = 3'd4;
	localparam logic [2:0] KIND_ROT_LEFT    = 3'd5;
	localparam logic [2:0] KIND_ROT_RIGHT   = 3'd6;

	// motor actions
	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_VEL  = 2'd1;
	localparam logic [1:0] ACT_LOCK = 2'd2;

	// stroke phases
	localparam logic [1:0] PHASE_TO_B2  = 2'd0;
	localparam logic [1:0] PHASE_RETURN = 2'd1;
	localparam logic [1:0] PHASE_DONE   = 2'd2;

	// register indexes
	localparam logic [2:0] REG_LOW_SPEED     = 3'd0;
	localparam logic [2:0] REG_HIGH_SPEED    = 3'd1;
	localparam logic [2:0] REG_PIVOT_SPEED   = 3'd2;
	localparam logic [2:0] REG_B1_NEGATIVE   = 3'd3;
	localparam logic [2:0] REG_LOW_MIN_RUN   = 3'd4;
	localparam logic [2:0] REG_PIVOT_WINDOW  = 3'd5;

	// fixed speeds and limits
	localparam int unsigned SPEED_W        = 11;
	localparam int unsigned VEL_W          = 12;
	localparam int unsigned CFG_W          = 16;
	localparam logic [SPEED_W-1:0] SPEED_MAX      = 11'd1799;
	localparam logic [VEL_W-1:0]   CAL_LOW_SPEED  = 12'd240;
	localparam logic [VEL_W-1:0]   CAL_HIGH_SPEED = 12'd300;
	localparam logic [1:0]         ARRIVALS_NEEDED = 2'd2;
	localparam logic [1:0]         ARRIVALS_MAX    = 2'd3;

	// register reset values
	localparam logic [SPEED_W-1:0] LOW_SPEED_RST   = 11'd1600;
	localparam logic [SPEED_W-1:0] HIGH_SPEED_RST  = 11'd1200;
	localparam logic [SPEED_W-1:0] PIVOT_SPEED_RST = 11'd600;
	localparam logic [15:0]        LOW_MIN_RUN_RST = 16'd100;
	localparam logic [15:0]        PIVOT_WIN_RST   = 16'd15;

	// speed register limited to the motor maximum, as a signed velocity
	function automatic logic signed [VEL_W-1:0] clamp_speed(input logic [SPEED_W-1:0] s);
		logic [SPEED_W-1:0] c;
		c = (s > SPEED_MAX) ? SPEED_MAX : s;
		return $signed({1'b0, c});
	endfunction

	// velocity magnitude with a selected direction
	function automatic logic signed [VEL_W-1:0] direct(input logic signed [VEL_W-1:0] mag,
			input logic negate);
		return negate ? -mag : mag;
	endfunction

endpackage

### rtl/racket_motor_sequencer.sv
// top level of the racket motor sequencer: input register, sequencers, result register
`timescale 1ns / 1ps

// Racket motor sequencer. Requests enter through an input register; when a request leaves it,
// the low racket, high racket and pivot sequencers update their state and an update request
// loads the result register, which holds a result while out_stall is high. One request is
// taken every clock while results are taken; only a stalled result register holds the input
// register, and command requests pass through without a result slot. Configuration writes
// are registered through cfg_we, cfg_index and cfg_data.
`include "racket_motor_sequencer_defines.svh"

module racket_motor_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	// configuration write port
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	// request channel
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          kind,
	input  logic [31:0]         now_ticks,
	input  logic                s1_pressed,
	input  logic                s2_pressed,
	input  logic                b1_hit,
	input  logic                b2_hit,
	input  logic                b3_hit,
	input  logic signed [31:0]  encoder_six,
	// result channel
	output logic                out_valid,
	input  logic                out_stall,
	output logic [1:0]          low_action,
	output logic signed [11:0]  low_velocity,
	output logic [1:0]          high_action,
	output logic signed [11:0]  high_velocity,
	output logic [1:0]          pivot_action,
	output logic signed [11:0]  pivot_velocity,
	output logic [1:0]          stroke_phase,
	output logic                low_ready,
	output logic                high_ready,
	output logic signed [31:0]  b1_position,
	output logic signed [31:0]  b2_position
);

	// configuration registers
	logic [10:0] low_speed_q, high_speed_q, pivot_speed_q;
	logic        b1_negative_q;
	logic [15:0] low_min_run_q, pivot_window_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_speed_q    <= rms_pkg::LOW_SPEED_RST;
			high_speed_q   <= rms_pkg::HIGH_SPEED_RST;
			pivot_speed_q  <= rms_pkg::PIVOT_SPEED_RST;
			b1_negative_q  <= 1'b0;
			low_min_run_q  <= rms_pkg::LOW_MIN_RUN_RST;
			pivot_window_q <= rms_pkg::PIVOT_WIN_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				rms_pkg::REG_LOW_SPEED:    low_speed_q    <= cfg_data[10:0];
				rms_pkg::REG_HIGH_SPEED:   high_speed_q   <= cfg_data[10:0];
				rms_pkg::REG_PIVOT_SPEED:  pivot_speed_q  <= cfg_data[10:0];
				rms_pkg::REG_B1_NEGATIVE:  b1_negative_q  <= cfg_data[0];
				rms_pkg::REG_LOW_MIN_RUN:  low_min_run_q  <= cfg_data;
				rms_pkg::REG_PIVOT_WINDOW: pivot_window_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register
	logic               valid_s1;
	logic [2:0]         kind_s1;
	logic [31:0]        now_s1;
	logic               s1p_s1, s2p_s1, b1_s1, b2_s1, b3_s1;
	logic [31:0]        enc_s1;
	logic               is_update, advance;

	assign is_update = (kind_s1 == rms_pkg::KIND_UPDATE);
	assign advance   = valid_s1 && (!is_update || !out_valid || !out_stall);
	assign in_stall  = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1 <= kind;
			now_s1  <= now_ticks;
			s1p_s1  <= s1_pressed;
			s2p_s1  <= s2_pressed;
			b1_s1   <= b1_hit;
			b2_s1   <= b2_hit;
			b3_s1   <= b3_hit;
			enc_s1  <= encoder_six;
		end
	end

	// sequencer state
	logic        low_cal_active_q, low_cal_done_q, b3_was_clear_q, low_running_q;
	logic [1:0]  b3_arrivals_q;
	logic [31:0] low_start_q;
	logic        high_cal_active_q, high_cal_done_q, high_running_q;
	logic [1:0]  phase_q;
	logic [31:0] b1_count_q, b2_count_q;
	logic [31:0] left_time_q, right_time_q;
	logic        left_valid_q, right_valid_q;

	logic        low_cal_active_d, low_cal_done_d, b3_was_clear_d, low_running_d;
	logic [1:0]  b3_arrivals_d;
	logic [31:0] low_start_d;
	logic        high_cal_active_d, high_cal_done_d, high_running_d;
	logic [1:0]  phase_d;
	logic [31:0] b1_count_d, b2_count_d;
	logic [31:0] left_time_d, right_time_d;
	logic        left_valid_d, right_valid_d;

	logic [1:0]         la, ha, pa;
	logic signed [11:0] lv, hv, pv;
	logic [31:0]        low_elapsed, left_elapsed, right_elapsed;
	logic signed [11:0] high_mag, pivot_mag;

	assign low_elapsed   = now_s1 - low_start_q;
	assign left_elapsed  = now_s1 - left_time_q;
	assign right_elapsed = now_s1 - right_time_q;
	assign high_mag      = rms_pkg::clamp_speed(high_speed_q);
	assign pivot_mag     = rms_pkg::clamp_speed(pivot_speed_q);

	// next state and result for the request in the input register
	always_comb begin
		low_cal_active_d  = low_cal_active_q;
		low_cal_done_d    = low_cal_done_q;
		b3_was_clear_d    = b3_was_clear_q;
		low_running_d     = low_running_q;
		b3_arrivals_d     = b3_arrivals_q;
		low_start_d       = low_start_q;
		high_cal_active_d = high_cal_active_q;
		high_cal_done_d   = high_cal_done_q;
		high_running_d    = high_running_q;
		phase_d           = phase_q;
		b1_count_d        = b1_count_q;
		b2_count_d        = b2_count_q;
		left_time_d       = left_time_q;
		right_time_d      = right_time_q;
		left_valid_d      = left_valid_q;
		right_valid_d     = right_valid_q;
		la = rms_pkg::ACT_NONE;
		ha = rms_pkg::ACT_NONE;
		pa = rms_pkg::ACT_LOCK;
		lv = '0;
		hv = '0;
		pv = '0;

		case (kind_s1)
			rms_pkg::KIND_LOW_MOVE: begin
				low_running_d = 1'b1;
				low_start_d   = now_s1;
			end
			rms_pkg::KIND_LOW_CAL: begin
				low_cal_active_d = 1'b1;
				b3_arrivals_d    = 2'd0;
			end
			rms_pkg::KIND_HIGH_MOVE: begin
				high_running_d = 1'b1;
				phase_d        = rms_pkg::PHASE_TO_B2;
			end
			rms_pkg::KIND_HIGH_CAL: begin
				high_cal_active_d = 1'b1;
			end
			rms_pkg::KIND_ROT_LEFT: begin
				left_time_d  = now_s1;
				left_valid_d = 1'b1;
			end
			rms_pkg::KIND_ROT_RIGHT: begin
				right_time_d  = now_s1;
				right_valid_d = 1'b1;
			end
			rms_pkg::KIND_UPDATE: begin
				// low racket: count b3 arrivals, then run until b3 after the minimum run
				if (low_cal_active_q) begin
					if (!b3_s1) begin
						la = rms_pkg::ACT_VEL;
						lv = rms_pkg::CAL_LOW_SPEED;
						b3_was_clear_d = 1'b1;
					end else begin
						if (b3_was_clear_q) begin
							if (b3_arrivals_q != rms_pkg::ARRIVALS_MAX) begin
								b3_arrivals_d = b3_arrivals_q + 2'd1;
							end
							b3_was_clear_d = 1'b0;
						end
						if (b3_arrivals_d >= rms_pkg::ARRIVALS_NEEDED) begin
							la = rms_pkg::ACT_LOCK;
							low_cal_active_d = 1'b0;
							low_cal_done_d   = 1'b1;
						end
					end
				end else if (low_cal_done_q) begin
					if (b3_s1 && (low_elapsed > {16'd0, low_min_run_q})) begin
						low_running_d = 1'b0;
					end
					if (low_running_d) begin
						la = rms_pkg::ACT_VEL;
						lv = rms_pkg::clamp_speed(low_speed_q);
					end else begin
						la = rms_pkg::ACT_LOCK;
					end
				end

				// high racket: record b1 and b2, return to b1; later stroke to b2 and back
				if (high_cal_active_q) begin
					if (b1_count_q == 32'd0) begin
						if (!b1_s1) begin
							ha = rms_pkg::ACT_VEL;
							hv = rms_pkg::direct(rms_pkg::CAL_HIGH_SPEED, b1_negative_q);
						end else begin
							ha = rms_pkg::ACT_LOCK;
							b1_count_d = enc_s1;
						end
					end else if (b2_count_q == 32'd0) begin
						if (!b2_s1) begin
							ha = rms_pkg::ACT_VEL;
							hv = rms_pkg::direct(rms_pkg::CAL_HIGH_SPEED, !b1_negative_q);
						end else begin
							ha = rms_pkg::ACT_LOCK;
							b2_count_d = enc_s1;
						end
					end else begin
						if (!b1_s1) begin
							ha = rms_pkg::ACT_VEL;
							hv = rms_pkg::direct(rms_pkg::CAL_HIGH_SPEED, b1_negative_q);
						end else begin
							ha = rms_pkg::ACT_LOCK;
							high_cal_done_d   = 1'b1;
							high_cal_active_d = 1'b0;
						end
					end
				end else if (high_cal_done_q && high_running_q) begin
					if (phase_q == rms_pkg::PHASE_TO_B2 && b2_s1) begin
						phase_d = rms_pkg::PHASE_RETURN;
					end else if (phase_q == rms_pkg::PHASE_RETURN && b1_s1) begin
						phase_d = rms_pkg::PHASE_DONE;
					end
					case (phase_d)
						rms_pkg::PHASE_TO_B2: begin
							ha = rms_pkg::ACT_VEL;
							hv = rms_pkg::direct(high_mag, !b1_negative_q);
						end
						rms_pkg::PHASE_RETURN: begin
							ha = rms_pkg::ACT_VEL;
							hv = rms_pkg::direct(high_mag, b1_negative_q);
						end
						rms_pkg::PHASE_DONE: ha = rms_pkg::ACT_LOCK;
						default: ;
					endcase
				end

				// pivot: drive while a rotate request is inside the window and its switch is not pressed, left first
				if (!s1p_s1 && left_valid_q && (left_elapsed < {16'd0, pivot_window_q})) begin
					pa = rms_pkg::ACT_VEL;
					pv = -pivot_mag;
				end else if (!s2p_s1 && right_valid_q
						&& (right_elapsed < {16'd0, pivot_window_q})) begin
					pa = rms_pkg::ACT_VEL;
					pv = pivot_mag;
				end
			end
			default: ;
		endcase
	end

	// state update when the request leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_cal_active_q  <= 1'b0;
			low_cal_done_q    <= 1'b0;
			b3_was_clear_q    <= 1'b1;
			low_running_q     <= 1'b0;
			b3_arrivals_q     <= 2'd0;
			low_start_q       <= 32'd0;
			high_cal_active_q <= 1'b0;
			high_cal_done_q   <= 1'b0;
			high_running_q    <= 1'b0;
			phase_q           <= rms_pkg::PHASE_TO_B2;
			b1_count_q        <= 32'd0;
			b2_count_q        <= 32'd0;
			left_time_q       <= 32'd0;
			right_time_q      <= 32'd0;
			left_valid_q      <= 1'b0;
			right_valid_q     <= 1'b0;
		end else if (advance) begin
			low_cal_active_q  <= low_cal_active_d;
			low_cal_done_q    <= low_cal_done_d;
			b3_was_clear_q    <= b3_was_clear_d;
			low_running_q     <= low_running_d;
			b3_arrivals_q     <= b3_arrivals_d;
			low_start_q       <= low_start_d;
			high_cal_active_q <= high_cal_active_d;
			high_cal_done_q   <= high_cal_done_d;
			high_running_q    <= high_running_d;
			phase_q           <= phase_d;
			b1_count_q        <= b1_count_d;
			b2_count_q        <= b2_count_d;
			left_time_q       <= left_time_d;
			right_time_q      <= right_time_d;
			left_valid_q      <= left_valid_d;
			right_valid_q     <= right_valid_d;
		end
	end

	// result register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && is_update) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_update) begin
			low_action     <= la;
			low_velocity   <= lv;
			high_action    <= ha;
			high_velocity  <= hv;
			pivot_action   <= pa;
			pivot_velocity <= pv;
			stroke_phase   <= phase_d;
			low_ready      <= low_cal_done_d;
			high_ready     <= high_cal_done_d;
			b1_position    <= b1_count_d;
			b2_position    <= b2_count_d;
		end
	end

	assign out_valid = out_valid_q;

	// checks on sequencer and result logic
	`RMS_ASSERT_NEXT(a_result_held, clk, arst_n, out_valid_q && out_stall, out_valid_q,
		"stalled result dropped")
	`RMS_ASSERT_NOW(a_pivot_acts, clk, arst_n, out_valid_q,
		pivot_action == rms_pkg::ACT_VEL || pivot_action == rms_pkg::ACT_LOCK,
		"pivot result without action")
	`RMS_ASSERT_NOW(a_low_vel_zero, clk, arst_n, out_valid_q,
		low_action == rms_pkg::ACT_VEL || low_velocity == 12'sd0,
		"low velocity without velocity action")
	`RMS_ASSERT_NOW(a_phase_legal, clk, arst_n, 1'b1, phase_q != 2'd3,
		"stroke phase out of range")
	`RMS_ASSERT_NOW(a_stall_has_item, clk, arst_n, in_stall, valid_s1 && is_update,
		"input stalled without a pending update")

endmodule
